>>> sv/min_priority_queue_unit_assert.svh
// Assertion macros for the priority queue block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

>>> sv/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 6;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 32;
  localparam int PRI_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    logic occ;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/mpq_cell.sv
`default_nettype none

// One slot of the sorted chain. Insert: take the left neighbor if it is
// pushed right, else take the new entry if this slot is the insert point.
// Remove: take the right neighbor.
module mpq_cell (
  input  wire logic             clk,
  input  wire mpq_pkg::cell_ctl_t ctl,
  input  wire mpq_pkg::entry_t  new_ent,
  input  wire mpq_pkg::entry_t  left_ent,
  input  wire logic             left_gt,
  input  wire mpq_pkg::entry_t  right_ent,
  output mpq_pkg::entry_t       ent,
  output logic                  gt
);

  // an empty slot counts as greater so the first free one takes the entry
  assign gt = !ctl.occ || (ent.pri > new_ent.pri);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      mpq_pkg::OP_INS: begin
        if (left_gt) begin
          ent <= left_ent;
        end else if (gt) begin
          ent <= new_ent;
        end
      end
      mpq_pkg::OP_REM: begin
        ent <= right_ent;
      end
      default: begin
        ent <= ent;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/min_priority_queue_unit.sv
// Channel   Dir  tdata (low bit up)                             tuser
// s_axis    in   item_data[31:0] item_priority[39:32]           func[0]
// m_axis    out  removed_data[31:0] removed_priority[39:32]     status[1:0]
//                entry_count[45:40]
// cfg       in   cfg_wdata = capacity[5:0], written when cfg_we
//
// One item per cycle unless the output stalls; the result is registered
// and valid in the next cycle. The cell row shifts every slot together.
// A new beat is taken while the result register is empty or being drained.
// Reset (rst, synchronous) empties the queue and sets capacity to 32.
// A stalled output holds its result and stops input until taken.
`default_nettype none

module min_priority_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // item_data, item_priority
  input  wire logic        s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // removed_data, removed_priority, entry_count
  output logic [1:0]       m_axis_tuser,   // status
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);

  localparam int DEPTH = mpq_pkg::DEPTH;
  localparam int CNT_W = mpq_pkg::CNT_W;
  localparam int CMP_W = mpq_pkg::CMP_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [mpq_pkg::CAP_W-1:0] capacity;

  logic acc;
  logic full;
  logic empty;
  logic [1:0] op;
  logic [1:0] status_next;
  mpq_pkg::entry_t new_ent;
  mpq_pkg::entry_t rem_ent;
  mpq_pkg::entry_t cell_ent [DEPTH];
  logic [DEPTH-1:0] cell_gt;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  assign new_ent.data = s_axis_tdata[31:0];
  assign new_ent.pri = s_axis_tdata[39:32];

  assign full = (CMP_W'(count) >= CMP_W'(capacity)) || (count >= CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    op = mpq_pkg::OP_HOLD;
    status_next = mpq_pkg::ST_DONE;
    count_next = count;
    rem_ent = '0;
    if (s_axis_tuser == mpq_pkg::FUNC_INSERT) begin
      if (full) begin
        status_next = mpq_pkg::ST_OVERFLOW;
      end else begin
        op = mpq_pkg::OP_INS;
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = mpq_pkg::ST_UNDERFLOW;
      end else begin
        op = mpq_pkg::OP_REM;
        count_next = count - 1'b1;
        rem_ent = cell_ent[0];
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      mpq_pkg::cell_ctl_t ctl;
      mpq_pkg::entry_t left_ent;
      mpq_pkg::entry_t right_ent;
      logic left_gt;

      assign ctl.op = acc ? op : mpq_pkg::OP_HOLD;
      assign ctl.occ = (CNT_W'(gi) < count);

      if (gi == 0) begin : g_first
        assign left_ent = new_ent;
        assign left_gt = 1'b0;
      end else begin : g_inner
        assign left_ent = cell_ent[gi-1];
        assign left_gt = cell_gt[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right_ent = new_ent;
      end else begin : g_mid
        assign right_ent = cell_ent[gi+1];
      end

      mpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_ent   (new_ent),
        .left_ent  (left_ent),
        .left_gt   (left_gt),
        .right_ent (right_ent),
        .ent       (cell_ent[gi]),
        .gt        (cell_gt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      capacity <= mpq_pkg::CAP_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (acc) begin
        count <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result payload, loaded on every accepted beat
  always_ff @(posedge clk) begin
    if (acc) begin
      m_axis_tuser <= status_next;
      m_axis_tdata <= {2'b00, 6'(count_next), rem_ent.pri, rem_ent.data};
    end
  end

  logic ins_ok;
  logic rem_empty;
  logic uflow_seen;
  logic head_ordered;

  assign ins_ok = acc && (s_axis_tuser == mpq_pkg::FUNC_INSERT) && !full;
  assign rem_empty = acc && (s_axis_tuser == mpq_pkg::FUNC_REMOVE) && empty;
  assign uflow_seen = (m_axis_tuser == mpq_pkg::ST_UNDERFLOW) && (count == '0);
  assign head_ordered = (cell_ent[0].pri <= cell_ent[1].pri);

`include "min_priority_queue_unit_assert.svh"

  `ASSERT_NEVER(a_count_range, count > CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_ins_count, ins_ok |=> count == $past(count) + 1'b1, "insert did not grow count")
  `ASSERT_CLK(a_underflow, rem_empty |=> uflow_seen, "remove on empty not flagged")
  `ASSERT_CLK(a_sorted_head, (count >= CNT_W'(2)) |-> head_ordered, "head of chain out of order")
  `ASSERT_CLK(a_hold_count, !acc |=> count == $past(count), "count moved without a beat")

endmodule

`default_nettype wire

>>> tb/sv/tb_min_priority_queue_unit.sv
`default_nettype none

module tb_min_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTED = 60;

  typedef struct packed {
    logic                       func;
    logic [mpq_pkg::DATA_W-1:0] data;
    logic [mpq_pkg::PRI_W-1:0]  pri;
  } q_item_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [mpq_pkg::DATA_W-1:0] rdata;
    logic [mpq_pkg::PRI_W-1:0]  rpri;
    logic [5:0]                 count;
  } q_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // item_data, item_priority
  logic        s_axis_tuser = 1'b0; // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // removed_data, removed_priority, entry_count
  logic [1:0]  m_axis_tuser;        // status
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;

  min_priority_queue_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Pending beats, expected results and the shadow of the sorted chain
  q_item_t         pend_items[$];
  q_result_t       exp_results[$];
  mpq_pkg::entry_t chain[mpq_pkg::DEPTH];
  int unsigned     chain_count = 0;
  logic [5:0]      cap_shadow = mpq_pkg::CAP_RESET;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        in_taken = 1'b0;
  int          err_count = 0;
  int          quiet_cycles = 0;

  function automatic q_result_t predict_queue_op(q_item_t it);
    q_result_t   r;
    int unsigned lim;
    int          pos;
    r = '0;
    r.status = mpq_pkg::ST_DONE;
    lim = (cap_shadow > mpq_pkg::DEPTH) ? mpq_pkg::DEPTH : cap_shadow;
    if (it.func == mpq_pkg::FUNC_INSERT) begin
      if (chain_count >= lim || chain_count >= mpq_pkg::DEPTH) begin
        r.status = mpq_pkg::ST_OVERFLOW;
      end else begin
        // new entry goes behind every held entry of equal priority
        pos = chain_count;
        while (pos > 0 && chain[pos-1].pri > it.pri) begin
          chain[pos] = chain[pos-1];
          pos--;
        end
        chain[pos].data = it.data;
        chain[pos].pri = it.pri;
        chain_count++;
      end
    end else begin
      if (chain_count == 0) begin
        r.status = mpq_pkg::ST_UNDERFLOW;
      end else begin
        r.rdata = chain[0].data;
        r.rpri = chain[0].pri;
        for (int i = 1; i < chain_count; i++) chain[i-1] = chain[i];
        chain_count--;
      end
    end
    r.count = 6'(chain_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < MAX_PRINTED)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin
    q_item_t cur;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_taken) begin
        if (pend_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur = pend_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur.pri, cur.data};
          s_axis_tuser <= cur.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: sample on the rising edge, check results, then predict new beats
  always @(posedge clk) begin
    q_result_t want;
    q_item_t   it;
    logic      s_beat;
    logic      m_beat;
    if (rst) begin
      in_taken <= 1'b0;
      chain_count = 0;
      cap_shadow = mpq_pkg::CAP_RESET;
      quiet_cycles = 0;
    end else begin
      s_beat = s_axis_tvalid && s_axis_tready;
      m_beat = m_axis_tvalid && m_axis_tready;
      in_taken <= s_beat;
      if (cfg_we) cap_shadow = cfg_wdata;
      if (m_beat) begin
        if (exp_results.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata[31:0],
                          32'(m_axis_tuser));
        end else begin
          want = exp_results.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
          if (m_axis_tdata[31:0] !== want.rdata)
            report_mismatch("removed_data", m_axis_tdata[31:0], want.rdata);
          if (m_axis_tdata[39:32] !== want.rpri)
            report_mismatch("removed_priority", 32'(m_axis_tdata[39:32]), 32'(want.rpri));
          if (m_axis_tdata[45:40] !== want.count)
            report_mismatch("entry_count", 32'(m_axis_tdata[45:40]), 32'(want.count));
        end
      end
      if (s_beat) begin
        it.func = s_axis_tuser;
        it.data = s_axis_tdata[31:0];
        it.pri = s_axis_tdata[39:32];
        exp_results.push_back(predict_queue_op(it));
      end
      if (s_beat || m_beat) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_op(logic func, logic [mpq_pkg::DATA_W-1:0] data,
                         logic [mpq_pkg::PRI_W-1:0] pri);
    q_item_t it;
    it.func = func;
    it.data = data;
    it.pri = pri;
    pend_items.push_back(it);
  endtask

  // Hold until every beat is in and every result is out
  task automatic drain_all();
    while (pend_items.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [5:0] value);
    drain_all();
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [mpq_pkg::PRI_W-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return mpq_pkg::PRI_W'($urandom_range(3));
    if (sel < 55) return '0;
    if (sel < 65) return '1;
    return mpq_pkg::PRI_W'($urandom);
  endfunction

  function automatic logic [mpq_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Sweep the fill level between empty and full, with some overrun at both ends
  task automatic queue_random_ops(int n);
    int  cnt;
    int  lim;
    bit  filling;
    bit  is_ins;
    cnt = int'(chain_count);
    lim = (cap_shadow > mpq_pkg::DEPTH) ? mpq_pkg::DEPTH : cap_shadow;
    filling = 1'b1;
    repeat (n) begin
      is_ins = filling ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
      if ($urandom_range(99) < 6) is_ins = 1'($urandom_range(1));
      push_op(is_ins ? mpq_pkg::FUNC_INSERT : mpq_pkg::FUNC_REMOVE,
              pick_data(), pick_priority());
      if (is_ins) begin
        if (cnt < lim) cnt++;
      end else begin
        if (cnt > 0) cnt--;
      end
      if (filling && cnt >= lim && $urandom_range(3) == 0) filling = 1'b0;
      else if (!filling && cnt == 0 && $urandom_range(2) == 0) filling = 1'b1;
      else if ($urandom_range(149) == 0) filling = !filling;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, ties and underflow at reset capacity, no idling
    idle_pct = 0;
    stall_pct = 0;
    push_op(mpq_pkg::FUNC_REMOVE, 32'h1234_5678, 8'h55);
    push_op(mpq_pkg::FUNC_INSERT, 32'h8000_0000, 8'hff);
    push_op(mpq_pkg::FUNC_INSERT, 32'h7fff_ffff, 8'h00);
    push_op(mpq_pkg::FUNC_INSERT, 32'h0000_0000, 8'h80);
    push_op(mpq_pkg::FUNC_INSERT, 32'hffff_ffff, 8'h00);
    push_op(mpq_pkg::FUNC_INSERT, 32'h0000_0005, 8'hff);
    repeat (5) push_op(mpq_pkg::FUNC_REMOVE, 32'hffff_ffff, 8'hff);
    push_op(mpq_pkg::FUNC_REMOVE, 32'h0, 8'h0);
    push_op(mpq_pkg::FUNC_INSERT, 32'd1, 8'd7);
    push_op(mpq_pkg::FUNC_INSERT, 32'd4, 8'd6);
    push_op(mpq_pkg::FUNC_INSERT, 32'd2, 8'd7);
    push_op(mpq_pkg::FUNC_INSERT, 32'd3, 8'd7);
    repeat (4) push_op(mpq_pkg::FUNC_REMOVE, 32'h0, 8'h0);

    // smallest nonzero capacity: second insert overflows
    write_capacity(6'd1);
    push_op(mpq_pkg::FUNC_INSERT, 32'hdead_beef, 8'h10);
    push_op(mpq_pkg::FUNC_INSERT, 32'hcafe_f00d, 8'h01);
    push_op(mpq_pkg::FUNC_REMOVE, 32'h0, 8'h0);
    push_op(mpq_pkg::FUNC_REMOVE, 32'h0, 8'h0);
    queue_random_ops(30);

    write_capacity(6'd32);
    idle_pct = 74;
    stall_pct = 0;
    queue_random_ops(200);

    // capacity beyond depth saturates
    write_capacity(6'd63);
    idle_pct = 0;
    stall_pct = 74;
    queue_random_ops(150);

    // zero capacity: every insert overflows
    write_capacity(6'd0);
    idle_pct = 30;
    stall_pct = 30;
    push_op(mpq_pkg::FUNC_INSERT, 32'h1, 8'h0);
    push_op(mpq_pkg::FUNC_INSERT, 32'h2, 8'hff);
    queue_random_ops(8);

    write_capacity(6'($urandom_range(31, 2)));
    queue_random_ops(150);

    // fill, then lower the capacity below the held count
    write_capacity(6'd32);
    idle_pct = 0;
    stall_pct = 0;
    repeat (20) push_op(mpq_pkg::FUNC_INSERT, pick_data(), pick_priority());
    write_capacity(6'd8);
    idle_pct = 74;
    queue_random_ops(60);

    write_capacity(6'd32);
    idle_pct = 30;
    stall_pct = 30;
    queue_random_ops(150);

    drain_all();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
